[rtl/core/hrf_pkg.sv]
// ----------------------------------------------------------------------------
// Homopolymer run finder package
// Shared command codes, request classification types, status codes and
// configuration constants for the run finder blocks.
// ----------------------------------------------------------------------------
package hrf_pkg;

   // Default widths of position/length counters and of the track register.
   localparam int POS_BITS_DEFAULT   = 32;
   localparam int TRACK_BITS_DEFAULT = 16;

   // Command codes carried by a request.
   localparam logic [1:0] CMD_BASE  = 2'd0;
   localparam logic [1:0] CMD_TRACK = 2'd1;
   localparam logic [1:0] CMD_END   = 2'd2;

   // Base codes that never extend a run.
   localparam logic [7:0] BASE_IGNORED = 8'h4E;
   localparam logic [7:0] BASE_NONE    = 8'h00;

   // Result status codes.
   localparam logic STATUS_RUN      = 1'b0;
   localparam logic STATUS_NO_TRACK = 1'b1;

   // Minimum run length register.
   localparam logic [15:0] MIN_REPEATS_RESET = 16'd2;
   localparam logic [15:0] MIN_REPEATS_FLOOR = 16'd2;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // Kind of a classified request.
   typedef enum logic [1:0] {
      KIND_BASE,
      KIND_TRACK,
      KIND_END
   } kind_type;

   // A classified request as it travels through the queue.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  base;
      logic        countable;
      logic [15:0] track;
   } item_type;

   // A queue slot: an item together with its valid flag.
   typedef struct packed {
      logic     valid;
      item_type item;
   } slot_type;

endpackage

[rtl/core/hrf_front.sv]
// ----------------------------------------------------------------------------
// Homopolymer run finder front end
// Accepts requests, classifies the command, marks bases that can extend a
// run and holds the classified request until the queue takes it.
// ----------------------------------------------------------------------------
module hrf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_cmd,
   input  logic [7:0]        req_base_in,
   input  logic [15:0]       req_track_in,
   output hrf_pkg::slot_type push_slot,
   input  logic              push_ready
);

   logic              front_valid_ff;
   logic              front_valid_in;
   hrf_pkg::item_type front_item_ff;
   hrf_pkg::item_type front_item_in;
   logic              accept;
   logic              push;
   logic              keep;

   // The holding register frees up whenever the queue takes its contents.
   assign push      = front_valid_ff & push_ready;
   assign req_ready = ~front_valid_ff | push_ready;
   assign accept    = req_valid & req_ready;

   // Classify the incoming request; an unused command is dropped here.
   always_comb begin
      keep                    = 1'b1;
      front_item_in.kind      = hrf_pkg::KIND_BASE;
      front_item_in.base      = req_base_in;
      front_item_in.track     = req_track_in;
      front_item_in.countable = (req_base_in != hrf_pkg::BASE_IGNORED) &&
                                (req_base_in != hrf_pkg::BASE_NONE);
      case (req_cmd)
         hrf_pkg::CMD_BASE: begin
            front_item_in.kind = hrf_pkg::KIND_BASE;
         end
         hrf_pkg::CMD_TRACK: begin
            front_item_in.kind = hrf_pkg::KIND_TRACK;
         end
         hrf_pkg::CMD_END: begin
            front_item_in.kind = hrf_pkg::KIND_END;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // Next state of the holding register valid flag.
   always_comb begin
      front_valid_in = front_valid_ff;
      if (accept) begin
         front_valid_in = keep;
      end else if (push) begin
         front_valid_in = 1'b0;
      end
   end

   // Holding register.
   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      if (accept) begin
         front_item_ff <= front_item_in;
      end
   end

   assign push_slot.valid = front_valid_ff;
   assign push_slot.item  = front_item_ff;

endmodule

[rtl/core/hrf_queue.sv]
// ----------------------------------------------------------------------------
// Homopolymer run finder queue
// A short first-in first-out queue of classified requests that decouples
// the front end from the run tracker.
// ----------------------------------------------------------------------------
module hrf_queue (
   input  logic              clock,
   input  logic              reset,
   input  hrf_pkg::slot_type push_slot,
   output logic              push_ready,
   output hrf_pkg::slot_type head_slot,
   input  logic              pop
);

   localparam int DEPTH    = hrf_pkg::QUEUE_DEPTH;
   localparam int PTR_BITS = hrf_pkg::QUEUE_PTR_BITS;
   localparam int CNT_BITS = hrf_pkg::QUEUE_CNT_BITS;
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

   hrf_pkg::item_type   entries_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;
   logic                push;
   logic                do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign push       = push_slot.valid & push_ready;
   assign do_pop     = pop & (count_ff != '0);

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_slot.item;
      end
   end

   assign head_slot.valid = (count_ff != '0);
   assign head_slot.item  = entries_ff[rd_ptr_ff];

endmodule

[rtl/core/hrf_back.sv]
// ----------------------------------------------------------------------------
// Homopolymer run finder back end
// Tracks the current run, position and track, decides when a finished run
// is reported and holds the result in the output register.
// ----------------------------------------------------------------------------
module hrf_back #(
   parameter int POS_BITS   = hrf_pkg::POS_BITS_DEFAULT,
   parameter int TRACK_BITS = hrf_pkg::TRACK_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [15:0]       min_repeats,
   input  hrf_pkg::slot_type head_slot,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_status,
   output logic [15:0]       rsp_track_out,
   output logic [31:0]       rsp_run_start,
   output logic [31:0]       rsp_run_end,
   output logic [7:0]        rsp_run_base,
   output logic [31:0]       rsp_run_length
);

   localparam int WIDE_BITS = 96;
   localparam int TRK_WIDE  = 48;
   localparam logic [POS_BITS-1:0] POS_ONE = {{(POS_BITS - 1){1'b0}}, 1'b1};

   // Run state.
   logic [7:0]            prev_base_ff;
   logic [7:0]            prev_base_in;
   logic [POS_BITS-1:0]   run_begin_ff;
   logic [POS_BITS-1:0]   run_begin_in;
   logic [POS_BITS-1:0]   run_count_ff;
   logic [POS_BITS-1:0]   run_count_in;
   logic [POS_BITS-1:0]   position_ff;
   logic [POS_BITS-1:0]   position_in;
   logic [TRACK_BITS-1:0] track_ff;
   logic [TRACK_BITS-1:0] track_in;
   logic                  track_seen_ff;
   logic                  track_seen_in;

   // Output register.
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  rsp_status_ff;
   logic [15:0]           rsp_track_out_ff;
   logic [31:0]           rsp_run_start_ff;
   logic [31:0]           rsp_run_end_ff;
   logic [7:0]            rsp_run_base_ff;
   logic [31:0]           rsp_run_length_ff;

   // Working signals.
   hrf_pkg::item_type     item;
   logic [15:0]           need;
   logic [WIDE_BITS-1:0]  count_wide;
   logic [WIDE_BITS-1:0]  need_wide;
   logic [WIDE_BITS-1:0]  begin_wide;
   logic [WIDE_BITS-1:0]  end_wide;
   logic [TRK_WIDE-1:0]   trk_req_wide;
   logic [TRK_WIDE-1:0]   trk_cur_wide;
   logic [POS_BITS:0]     end_sum;
   logic [POS_BITS-1:0]   end_sat;
   logic [POS_BITS-1:0]   count_inc;
   logic [POS_BITS-1:0]   position_inc;
   logic                  long_enough;
   logic                  res_valid;
   logic                  res_status;

   assign item = head_slot.item;

   // The back end takes the next request whenever the output register is
   // free or being emptied in this cycle.
   assign pop = head_slot.valid & (~rsp_valid_ff | rsp_ready);

   // Threshold compare; a minimum below the floor acts as the floor.
   assign need        = (min_repeats < hrf_pkg::MIN_REPEATS_FLOOR) ?
                        hrf_pkg::MIN_REPEATS_FLOOR : min_repeats;
   assign count_wide  = {{(WIDE_BITS - POS_BITS){1'b0}}, run_count_ff};
   assign need_wide   = {{(WIDE_BITS - 16){1'b0}}, need};
   assign long_enough = (count_wide >= need_wide);

   // Saturating exclusive end of the pending run.
   assign end_sum    = {1'b0, run_begin_ff} + {1'b0, run_count_ff};
   assign end_sat    = end_sum[POS_BITS] ? '1 : end_sum[POS_BITS-1:0];
   assign begin_wide = {{(WIDE_BITS - POS_BITS){1'b0}}, run_begin_ff};
   assign end_wide   = {{(WIDE_BITS - POS_BITS){1'b0}}, end_sat};

   // Saturating increments.
   assign count_inc    = (run_count_ff == '1) ? run_count_ff : run_count_ff + POS_ONE;
   assign position_inc = (position_ff == '1) ? position_ff : position_ff + POS_ONE;

   // Track number resized to the track register and back to the port.
   assign trk_req_wide = {{(TRK_WIDE - 16){1'b0}}, item.track};
   assign trk_cur_wide = {{(TRK_WIDE - TRACK_BITS){1'b0}}, track_ff};

   // Run state update for the request at the head of the queue.
   always_comb begin
      prev_base_in  = prev_base_ff;
      run_begin_in  = run_begin_ff;
      run_count_in  = run_count_ff;
      position_in   = position_ff;
      track_in      = track_ff;
      track_seen_in = track_seen_ff;
      res_valid     = 1'b0;
      res_status    = hrf_pkg::STATUS_RUN;
      case (item.kind)
         hrf_pkg::KIND_BASE: begin
            if (!track_seen_ff) begin
               res_valid  = 1'b1;
               res_status = hrf_pkg::STATUS_NO_TRACK;
            end else begin
               if (item.countable && (item.base == prev_base_ff)) begin
                  run_count_in = count_inc;
               end else begin
                  res_valid    = long_enough;
                  prev_base_in = item.base;
                  run_begin_in = position_ff;
                  run_count_in = POS_ONE;
               end
               position_in = position_inc;
            end
         end
         hrf_pkg::KIND_TRACK: begin
            res_valid     = track_seen_ff & long_enough;
            prev_base_in  = hrf_pkg::BASE_NONE;
            run_begin_in  = '0;
            run_count_in  = POS_ONE;
            position_in   = '0;
            track_in      = trk_req_wide[TRACK_BITS-1:0];
            track_seen_in = 1'b1;
         end
         hrf_pkg::KIND_END: begin
            res_valid     = track_seen_ff & long_enough;
            prev_base_in  = hrf_pkg::BASE_NONE;
            run_begin_in  = '0;
            run_count_in  = POS_ONE;
            position_in   = '0;
            track_in      = '0;
            track_seen_in = 1'b0;
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   // Output register valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = res_valid;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_base_ff  <= hrf_pkg::BASE_NONE;
         run_begin_ff  <= '0;
         run_count_ff  <= POS_ONE;
         position_ff   <= '0;
         track_ff      <= '0;
         track_seen_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (pop) begin
            prev_base_ff  <= prev_base_in;
            run_begin_ff  <= run_begin_in;
            run_count_ff  <= run_count_in;
            position_ff   <= position_in;
            track_ff      <= track_in;
            track_seen_ff <= track_seen_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload; an error result carries zeros besides its status.
   always_ff @(posedge clock) begin
      if (pop && res_valid) begin
         rsp_status_ff <= res_status;
         if (res_status == hrf_pkg::STATUS_NO_TRACK) begin
            rsp_track_out_ff  <= '0;
            rsp_run_start_ff  <= '0;
            rsp_run_end_ff    <= '0;
            rsp_run_base_ff   <= '0;
            rsp_run_length_ff <= '0;
         end else begin
            rsp_track_out_ff  <= trk_cur_wide[15:0];
            rsp_run_start_ff  <= begin_wide[31:0];
            rsp_run_end_ff    <= end_wide[31:0];
            rsp_run_base_ff   <= prev_base_ff;
            rsp_run_length_ff <= count_wide[31:0];
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_track_out  = rsp_track_out_ff;
   assign rsp_run_start  = rsp_run_start_ff;
   assign rsp_run_end    = rsp_run_end_ff;
   assign rsp_run_base   = rsp_run_base_ff;
   assign rsp_run_length = rsp_run_length_ff;

endmodule

[rtl/core/homopolymer_run_finder.sv]
// ----------------------------------------------------------------------------
// Homopolymer run finder
// Finds runs of one repeated base in a stream of tracks and reports each run
// that reaches the configured minimum length.
// ----------------------------------------------------------------------------
// Usage:
// A request carries a command: a base, the start of a new track with its
// number, or the end of the stream. Requests enter on the req_ channel and
// results leave on the rsp_ channel, both with valid/ready handshakes.
// A result reports a finished run (track, start, exclusive end, base and
// length) or flags a base that arrived before any track.
// One request is taken every clock cycle while req_ready is high; a result
// passes through the front holding register, the queue and the output
// register. A request causes at most one result. When the receiver stalls,
// the output register holds its result while the front end and the two-entry
// queue keep taking requests until they fill; req_ready then falls until the
// result is taken. The minimum run length register lies at byte address 0 of
// the csr_ port and is to be written by the user only while the block is
// idle, which the block does not enforce. Reset clears the run state, drops
// any queued request and sets the minimum run length to 2.
// ----------------------------------------------------------------------------
module homopolymer_run_finder #(
   parameter int POS_BITS   = hrf_pkg::POS_BITS_DEFAULT,
   parameter int TRACK_BITS = hrf_pkg::TRACK_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_base_in,
   input  logic [15:0] req_track_in,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic [15:0] rsp_track_out,
   output logic [31:0] rsp_run_start,
   output logic [31:0] rsp_run_end,
   output logic [7:0]  rsp_run_base,
   output logic [31:0] rsp_run_length,
   // Configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [15:0]       min_repeats_ff;
   logic [15:0]       min_repeats_in;
   logic              csr_write;
   logic              sel_min_repeats;
   hrf_pkg::slot_type push_slot;
   logic              push_ready;
   hrf_pkg::slot_type head_slot;
   logic              pop;

   // Register decode: the minimum run length is the only register.
   assign csr_pready      = 1'b1;
   assign sel_min_repeats = ~csr_paddr[2];
   assign csr_write       = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      min_repeats_in = min_repeats_ff;
      if (csr_write && sel_min_repeats) begin
         min_repeats_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_repeats_ff <= hrf_pkg::MIN_REPEATS_RESET;
      end else begin
         min_repeats_ff <= min_repeats_in;
      end
   end

   // Register read-back.
   assign csr_prdata = sel_min_repeats ? {16'd0, min_repeats_ff} : 32'd0;

   // Front end: accepts and classifies requests.
   hrf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_base_in  (req_base_in),
      .req_track_in (req_track_in),
      .push_slot    (push_slot),
      .push_ready   (push_ready)
   );

   // Queue between front and back.
   hrf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_slot  (push_slot),
      .push_ready (push_ready),
      .head_slot  (head_slot),
      .pop        (pop)
   );

   // Back end: run tracking and result register.
   hrf_back #(
      .POS_BITS   (POS_BITS),
      .TRACK_BITS (TRACK_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .min_repeats    (min_repeats_ff),
      .head_slot      (head_slot),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_track_out  (rsp_track_out),
      .rsp_run_start  (rsp_run_start),
      .rsp_run_end    (rsp_run_end),
      .rsp_run_base   (rsp_run_base),
      .rsp_run_length (rsp_run_length)
   );

endmodule

[sim/homopolymer_run_finder_tb.sv]
// ----------------------------------------------------------------------------
// Homopolymer run finder testbench
// Drives base, new-track, end-of-stream and unused requests into the run
// finder under random burst gaps and result-side stalls. A predictor tracks
// the runs on its own copy of the state and checks every result field by
// field. The minimum run length is changed between phases, including both
// ends of its range and values below the floor.
// ----------------------------------------------------------------------------
module homopolymer_run_finder_tb;

   // Command value that the block ignores.
   localparam logic [1:0] CMD_UNUSED       = 2'd3;
   localparam logic [2:0] MIN_REPEATS_ADDR = 3'd0;
   localparam logic [7:0] BASE_A           = 8'h41;
   localparam logic [7:0] BASE_C           = 8'h43;
   localparam logic [7:0] BASE_G           = 8'h47;
   localparam logic [7:0] BASE_T           = 8'h54;
   localparam int         SETTLE_CYCLES    = 16;
   localparam int         REPORT_LIMIT     = 10;
   localparam int         LONG_RUN         = 40;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  base;
      logic [15:0] track;
   } finder_request_type;

   typedef struct packed {
      logic        status;
      logic [15:0] track;
      logic [31:0] start_pos;
      logic [31:0] end_pos;
      logic [7:0]  base;
      logic [31:0] length;
   } run_report_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_COIN,
      READY_SPARSE
   } stall_mode_type;

   logic        clock;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd      = '0;
   logic [7:0]  req_base_in  = '0;
   logic [15:0] req_track_in = '0;
   logic        rsp_valid;
   logic        rsp_ready    = 1'b0;
   logic        rsp_status;
   logic [15:0] rsp_track_out;
   logic [31:0] rsp_run_start;
   logic [31:0] rsp_run_end;
   logic [7:0]  rsp_run_base;
   logic [31:0] rsp_run_length;
   logic        csr_psel     = 1'b0;
   logic        csr_penable  = 1'b0;
   logic        csr_pwrite   = 1'b0;
   logic [2:0]  csr_paddr    = '0;
   logic [31:0] csr_pwdata   = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Requests waiting to be sent and run reports waiting to arrive.
   finder_request_type requests_waiting[$];
   run_report_type     reports_due[$];

   // Predictor state and its copy of the minimum run length.
   logic [7:0]  seq_prev_base;
   logic [31:0] seq_run_begin;
   logic [31:0] seq_run_count;
   logic [31:0] seq_position;
   logic [15:0] seq_track;
   logic        seq_in_track;
   logic [15:0] seq_min_repeats;

   int          items_queued     = 0;
   int          requests_taken   = 0;
   int          runs_checked     = 0;
   int          no_track_checked = 0;
   int          settings_used    = 1;
   int          mismatch_count   = 0;

   logic           req_fire   = 1'b0;
   int             burst_left = 1;
   int             gap_left   = 0;
   stall_mode_type stall_mode = READY_ALWAYS;
   int             stall_left = 0;

   homopolymer_run_finder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_base_in    (req_base_in),
      .req_track_in   (req_track_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_track_out  (rsp_track_out),
      .rsp_run_start  (rsp_run_start),
      .rsp_run_end    (rsp_run_end),
      .rsp_run_base   (rsp_run_base),
      .rsp_run_length (rsp_run_length),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Positions and lengths stop at the all-ones value.
   function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] total;
      total = {1'b0, a} + {1'b0, b};
      return total[32] ? '1 : total[31:0];
   endfunction

   // Reports the pending run if it reaches the minimum length.
   task automatic close_run();
      logic [31:0] need;
      need = (seq_min_repeats < hrf_pkg::MIN_REPEATS_FLOOR) ?
             32'(hrf_pkg::MIN_REPEATS_FLOOR) : 32'(seq_min_repeats);
      if (seq_run_count >= need) begin
         reports_due.push_back(run_report_type'{hrf_pkg::STATUS_RUN, seq_track,
            seq_run_begin, sat_sum(seq_run_begin, seq_run_count), seq_prev_base,
            seq_run_count});
      end
   endtask

   task automatic restart_position();
      seq_prev_base = hrf_pkg::BASE_NONE;
      seq_run_begin = '0;
      seq_run_count = 32'd1;
      seq_position  = '0;
   endtask

   task automatic clear_finder();
      restart_position();
      seq_track    = '0;
      seq_in_track = 1'b0;
   endtask

   // Advances the predicted run state by one accepted request.
   task automatic track_runs(input logic [1:0] cmd, input logic [7:0] base,
                             input logic [15:0] track);
      case (cmd)
         hrf_pkg::CMD_BASE: begin
            if (!seq_in_track) begin
               reports_due.push_back(run_report_type'{hrf_pkg::STATUS_NO_TRACK, 16'd0,
                                                      32'd0, 32'd0, 8'd0, 32'd0});
            end else begin
               if (base == seq_prev_base && base != hrf_pkg::BASE_IGNORED &&
                   base != hrf_pkg::BASE_NONE) begin
                  seq_run_count = sat_sum(seq_run_count, 32'd1);
               end else begin
                  close_run();
                  seq_prev_base = base;
                  seq_run_begin = seq_position;
                  seq_run_count = 32'd1;
               end
               seq_position = sat_sum(seq_position, 32'd1);
            end
         end
         hrf_pkg::CMD_TRACK: begin
            if (seq_in_track) close_run();
            restart_position();
            seq_track    = track;
            seq_in_track = 1'b1;
         end
         hrf_pkg::CMD_END: begin
            if (seq_in_track) close_run();
            clear_finder();
         end
         default: begin
         end
      endcase
   endtask

   task automatic note_mismatch(input string what, input run_report_type want,
                                input run_report_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("mismatch, %s: expected st=%0d trk=%0d start=%0d end=%0d base=%02h len=%0d",
                  what, want.status, want.track, want.start_pos, want.end_pos, want.base,
                  want.length);
         $display("   got st=%0d trk=%0d start=%0d end=%0d base=%02h len=%0d",
                  got.status, got.track, got.start_pos, got.end_pos, got.base, got.length);
      end
   endtask

   // Sampling of both channels: results are checked, accepted requests predicted.
   always @(posedge clock) begin : channel_monitor
      run_report_type got;
      run_report_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_status, rsp_track_out, rsp_run_start, rsp_run_end, rsp_run_base,
                    rsp_run_length};
            if (reports_due.size() == 0) begin
               note_mismatch("result with none expected", '0, got);
            end else begin
               want = reports_due.pop_front();
               if (got.status !== want.status || got.track !== want.track ||
                   got.start_pos !== want.start_pos || got.end_pos !== want.end_pos ||
                   got.base !== want.base || got.length !== want.length) begin
                  note_mismatch("wrong result", want, got);
               end else if (want.status == hrf_pkg::STATUS_RUN) begin
                  runs_checked++;
               end else begin
                  no_track_checked++;
               end
            end
         end
         if (req_valid && req_ready) begin
            void'(requests_waiting.pop_front());
            track_runs(req_cmd, req_base_in, req_track_in);
            requests_taken++;
         end
      end
   end

   // Request driver: bursts of random length separated by random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         // The current request has not been taken yet, so it is held.
      end else if (gap_left != 0) begin
         gap_left  <= gap_left - 1;
         req_valid <= 1'b0;
      end else if (requests_waiting.size() == 0) begin
         req_valid <= 1'b0;
      end else begin
         req_valid    <= 1'b1;
         req_cmd      <= requests_waiting[0].cmd;
         req_base_in  <= requests_waiting[0].base;
         req_track_in <= requests_waiting[0].track;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 16);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end else begin
            burst_left <= burst_left - 1;
         end
      end
   end

   // Result-side stalls: the pattern is redrawn whenever its countdown runs out.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(16, 80);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
         READY_COIN:   rsp_ready <= ($urandom_range(0, 1) != 0);
         default:      rsp_ready <= (stall_left % 8 == 0);
      endcase
   end

   task automatic queue_request(input logic [1:0] cmd, input logic [7:0] base,
                                input logic [15:0] track);
      requests_waiting.push_back(finder_request_type'{cmd, base, track});
      if (cmd != CMD_UNUSED) items_queued++;
   endtask

   function automatic logic [7:0] pick_base();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         case ($urandom_range(0, 3))
            0:       return BASE_A;
            1:       return BASE_C;
            2:       return BASE_G;
            default: return BASE_T;
         endcase
      end
      if (roll < 85) return hrf_pkg::BASE_IGNORED;
      if (roll < 90) return hrf_pkg::BASE_NONE;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic int pick_run_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(1, 10);
      return $urandom_range(11, 40);
   endfunction

   // Mostly whole tracks of random runs, with some loose or broken requests.
   task automatic queue_random_streams(input int count);
      int         goal;
      int         len;
      logic [7:0] b;
      goal = items_queued + count;
      while (items_queued < goal) begin
         if ($urandom_range(0, 99) < 85) begin
            queue_request(hrf_pkg::CMD_TRACK, 8'($urandom_range(0, 255)),
                          16'($urandom_range(0, 65535)));
            repeat ($urandom_range(1, 12)) begin
               b   = pick_base();
               len = pick_run_length();
               repeat (len) queue_request(hrf_pkg::CMD_BASE, b,
                                          16'($urandom_range(0, 65535)));
               if ($urandom_range(0, 19) == 0) begin
                  queue_request(CMD_UNUSED, 8'($urandom_range(0, 255)),
                                16'($urandom_range(0, 65535)));
               end
            end
            if ($urandom_range(0, 9) < 6) begin
               queue_request(hrf_pkg::CMD_END, 8'($urandom_range(0, 255)),
                             16'($urandom_range(0, 65535)));
            end
         end else begin
            repeat ($urandom_range(1, 4)) begin
               queue_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                             16'($urandom_range(0, 65535)));
            end
         end
      end
   endtask

   // Waits until every request is taken and every report has arrived.
   task automatic wait_idle();
      while (requests_waiting.size() != 0 || reports_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the minimum run length and reads it back.
   task automatic set_min_repeats(input logic [15:0] value);
      logic [31:0] readback;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= MIN_REPEATS_ADDR;
      csr_pwdata  <= {16'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      seq_min_repeats = value;
      settings_used++;
      if (readback[15:0] !== value) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("mismatch, minimum run length read back as %0d, written %0d",
                     readback[15:0], value);
         end
      end
   endtask

   initial begin
      clear_finder();
      seq_min_repeats = hrf_pkg::MIN_REPEATS_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: base before any track, ignored commands, reserved bases,
      // flushing on a new track and at the end of the stream.
      queue_request(hrf_pkg::CMD_BASE, BASE_A, 16'h0000);
      queue_request(CMD_UNUSED, 8'hFF, 16'hFFFF);
      queue_request(hrf_pkg::CMD_END, 8'h00, 16'h0000);
      queue_request(hrf_pkg::CMD_TRACK, 8'h00, 16'hFFFF);
      repeat (3) queue_request(hrf_pkg::CMD_BASE, BASE_A, 16'h0000);
      repeat (2) queue_request(hrf_pkg::CMD_BASE, hrf_pkg::BASE_IGNORED, 16'h0000);
      repeat (2) queue_request(hrf_pkg::CMD_BASE, hrf_pkg::BASE_NONE, 16'hFFFF);
      repeat (2) queue_request(hrf_pkg::CMD_BASE, 8'hFF, 16'h0000);
      queue_request(CMD_UNUSED, 8'hFF, 16'h0000);
      queue_request(hrf_pkg::CMD_BASE, 8'hFF, 16'h0000);
      repeat (2) queue_request(hrf_pkg::CMD_BASE, BASE_C, 16'h0000);
      queue_request(hrf_pkg::CMD_TRACK, 8'hFF, 16'h0000);
      repeat (2) queue_request(hrf_pkg::CMD_BASE, BASE_G, 16'h0000);
      queue_request(hrf_pkg::CMD_END, 8'hFF, 16'hFFFF);
      queue_request(hrf_pkg::CMD_BASE, 8'hFF, 16'hFFFF);
      queue_request(hrf_pkg::CMD_TRACK, 8'h00, 16'h5AA5);
      queue_request(hrf_pkg::CMD_BASE, BASE_T, 16'h0000);
      queue_request(hrf_pkg::CMD_TRACK, 8'h00, 16'hA55A);
      repeat (2) queue_request(hrf_pkg::CMD_BASE, BASE_T, 16'h0000);
      queue_request(hrf_pkg::CMD_END, 8'h00, 16'h0000);
      wait_idle();

      set_min_repeats(16'd3);
      queue_random_streams(260);
      wait_idle();

      set_min_repeats(16'd0);
      queue_random_streams(260);
      wait_idle();

      set_min_repeats(16'd7);
      queue_random_streams(260);
      wait_idle();

      // Largest minimum: a long run still falls short of it.
      set_min_repeats(16'hFFFF);
      queue_request(hrf_pkg::CMD_TRACK, 8'h00, 16'($urandom_range(0, 65535)));
      repeat (LONG_RUN) queue_request(hrf_pkg::CMD_BASE, BASE_A, 16'h0000);
      queue_request(hrf_pkg::CMD_BASE, BASE_C, 16'h0000);
      queue_request(hrf_pkg::CMD_END, 8'h00, 16'h0000);
      queue_random_streams(100);
      wait_idle();

      set_min_repeats(16'd1);
      queue_random_streams(260);
      wait_idle();

      set_min_repeats(16'd2);
      queue_random_streams(260);
      wait_idle();

      $display("tb: %0d requests taken under %0d minimum run lengths", requests_taken,
               settings_used);
      $display("tb: %0d run reports and %0d no-track errors matched", runs_checked,
               no_track_checked);
      if (mismatch_count == 0 && reports_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Guard against a hang.
   initial begin
      #20000000;
      $display("tb: failure");
      $finish;
   end

endmodule
